[hdl/fnvnp_pkg.sv]
// ----------------------------------------------------------------------------
// fnvnp_pkg
// Shared types, constants and the FNV-1a byte step for the name pair hash.
// ----------------------------------------------------------------------------
`default_nettype none

package fnvnp_pkg;

  localparam logic [1:0] REQ_DATASET   = 2'd0;
  localparam logic [1:0] REQ_SEPARATOR = 2'd1;
  localparam logic [1:0] REQ_MEMBER    = 2'd2;
  localparam logic [1:0] REQ_FINISH    = 2'd3;

  localparam logic [31:0] BASIS_HI = 32'hCBF2_9CE4;
  localparam logic [31:0] BASIS_LO = 32'h8422_2325;
  localparam logic [63:0] BASIS    = {BASIS_HI, BASIS_LO};

  localparam logic [7:0] DATASET_NAME_MAX = 8'd44;
  localparam logic [7:0] MEMBER_NAME_MAX  = 8'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] file_hash;
    logic [31:0] folded_id;
  } result_t;

  // h ^ b, times prime 0x100000001B3 (mod 2^64) as shift-adds
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

`default_nettype wire

[hdl/fnvnp_in_stage.sv]
// ----------------------------------------------------------------------------
// fnvnp_in_stage
// Input register: holds one request beat until the hash stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvnp_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [1:0]      req_type_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            take_i,
  output logic                 item_valid_o,
  output fnvnp_pkg::item_t     item_o
);

  logic             valid_q, valid_d;
  fnvnp_pkg::item_t item_q;
  logic             accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{req_type: req_type_i, data_byte: data_byte_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[hdl/fnvnp_hash_unit.sv]
// ----------------------------------------------------------------------------
// fnvnp_hash_unit
// Running hash state, part tracking and finish/fold logic.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvnp_hash_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  input  wire fnvnp_pkg::item_t  item_i,
  input  wire logic              out_ready_i,
  output logic                   take_o,
  output logic                   res_valid_o,
  output fnvnp_pkg::result_t     res_o
);

  logic [63:0] hash_q, hash_d;
  logic [7:0]  count_q, count_d;
  logic        member_q, member_d;
  logic        is_finish;
  logic [63:0] mix_in;
  logic [7:0]  mix_byte;
  logic [63:0] mixed;
  logic [63:0] fin_hash;
  logic [31:0] fold;

  assign is_finish = (item_i.req_type == fnvnp_pkg::REQ_FINISH);
  assign take_o    = item_valid_i && (!is_finish || out_ready_i);

  assign mix_in   = hash_q;
  assign mix_byte = ((item_i.req_type == fnvnp_pkg::REQ_DATASET) ||
                     (item_i.req_type == fnvnp_pkg::REQ_MEMBER)) ? item_i.data_byte : 8'd0;
  assign mixed    = fnvnp_pkg::fnv_mix(mix_in, mix_byte);

  always_comb begin
    fin_hash = member_q ? hash_q : mixed;
    if (fin_hash == 64'd0) begin
      fin_hash = fnvnp_pkg::BASIS;
    end
    fold = fin_hash[63:32] ^ fin_hash[31:0];
    if (fold == 32'd0) begin
      fold = fnvnp_pkg::BASIS_LO;
    end
  end

  always_comb begin
    hash_d   = hash_q;
    count_d  = count_q;
    member_d = member_q;
    if (take_o) begin
      case (item_i.req_type)
        fnvnp_pkg::REQ_DATASET: begin
          if (!member_q && (count_q < fnvnp_pkg::DATASET_NAME_MAX)) begin
            hash_d  = mixed;
            count_d = count_q + 8'd1;
          end
        end
        fnvnp_pkg::REQ_SEPARATOR: begin
          if (!member_q) begin
            hash_d   = mixed;
            member_d = 1'b1;
            count_d  = 8'd0;
          end
        end
        fnvnp_pkg::REQ_MEMBER: begin
          if (member_q && (count_q < fnvnp_pkg::MEMBER_NAME_MAX)) begin
            hash_d  = mixed;
            count_d = count_q + 8'd1;
          end
        end
        default: begin
          hash_d   = fnvnp_pkg::BASIS;
          count_d  = 8'd0;
          member_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= fnvnp_pkg::BASIS;
      count_q  <= 8'd0;
      member_q <= 1'b0;
    end else begin
      hash_q   <= hash_d;
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  assign res_valid_o = take_o && is_finish;
  assign res_o       = '{file_hash: fin_hash, folded_id: fold};

endmodule

`default_nettype wire

[hdl/fnvnp_out_stage.sv]
// ----------------------------------------------------------------------------
// fnvnp_out_stage
// Result register: holds a finished hash beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvnp_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                res_valid_i,
  input  wire fnvnp_pkg::result_t  res_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [63:0]              file_hash_o,
  output logic [31:0]              folded_id_o
);

  logic               valid_q, valid_d;
  fnvnp_pkg::result_t res_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign file_hash_o = res_q.file_hash;
  assign folded_id_o = res_q.folded_id;

endmodule

`default_nettype wire

[hdl/fnv1a64_name_pair_hash_core.sv]
// ----------------------------------------------------------------------------
// fnv1a64_name_pair_hash_core
// 64-bit FNV-1a hash of a dataset/member name pair, one request per beat.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle (dataset byte, separator, member byte or
// finish); output stall holds only finish beats and the beats behind them.
// A byte or separator sits in the input register and is folded into the
// running hash in the following cycle; a finish beat's hash and 32-bit fold
// go into the output register once it can take them. Outside such holds, the
// throughput of one beat per clock is set by the running-hash feedback loop,
// a single multiply-by-prime shift-add network. Over-length and out-of-order
// bytes are dropped; finish reseeds the hash and clears the part state.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1a64_name_pair_hash_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      file_hash_o,
  output logic [31:0]      folded_id_o
);

  logic               item_valid;
  fnvnp_pkg::item_t   item;
  logic               take;
  logic               out_ready;
  logic               res_valid;
  fnvnp_pkg::result_t res;

  fnvnp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fnvnp_hash_unit u_hash (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_ready_i  (out_ready),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  fnvnp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .file_hash_o (file_hash_o),
    .folded_id_o (folded_id_o)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FNV-1a 64-bit name pair hash core.
// ----------------------------------------------------------------------------
// Sends dataset bytes, separators, member bytes and finish beats with random
// gaps, while the result side stalls at random. A scoreboard keeps its own
// copy of the running hash, byte count and part flag, and predicts the hash
// and fold of each finish beat. Each result beat is checked field by field
// against the oldest prediction. The random part is mostly well-formed name
// pairs, including names over the length limits, mixed with broken and noise
// sequences. One long receiver hold-off fills the core, and one sender pause
// drains all outstanding results.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [63:0] HASH_MULT       = 64'h0000_0100_0000_01B3;
  localparam int unsigned TOTAL_BEATS     = 850;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT      = 3000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  class fnv_pair_scoreboard;
    logic [63:0]        run_hash;
    logic [7:0]         part_len;
    bit                 member_part;
    fnvnp_pkg::result_t digest_q[$];
    int unsigned        error_count;

    function new();
      reseed();
      error_count = 0;
    endfunction

    function void reseed();
      run_hash    = fnvnp_pkg::BASIS;
      part_len    = 8'd0;
      member_part = 1'b0;
    endfunction

    function logic [63:0] mix(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * HASH_MULT;
    endfunction

    function void note_request(input logic [1:0] req, input logic [7:0] b);
      fnvnp_pkg::result_t r;
      logic [63:0]        h;
      logic [31:0]        fold;
      case (req)
        fnvnp_pkg::REQ_DATASET: begin
          if (!member_part && part_len < fnvnp_pkg::DATASET_NAME_MAX) begin
            run_hash = mix(run_hash, b);
            part_len = part_len + 8'd1;
          end
        end
        fnvnp_pkg::REQ_SEPARATOR: begin
          if (!member_part) begin
            run_hash    = mix(run_hash, 8'd0);
            member_part = 1'b1;
            part_len    = 8'd0;
          end
        end
        fnvnp_pkg::REQ_MEMBER: begin
          if (member_part && part_len < fnvnp_pkg::MEMBER_NAME_MAX) begin
            run_hash = mix(run_hash, b);
            part_len = part_len + 8'd1;
          end
        end
        fnvnp_pkg::REQ_FINISH: begin
          h = member_part ? run_hash : mix(run_hash, 8'd0);
          if (h == 64'd0) h = fnvnp_pkg::BASIS;
          fold = h[63:32] ^ h[31:0];
          if (fold == 32'd0) fold = fnvnp_pkg::BASIS_LO;
          r.file_hash = h;
          r.folded_id = fold;
          digest_q.push_back(r);
          reseed();
        end
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return digest_q.size();
    endfunction

    task report(input string msg);
      $display("tb: error at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_digest(input logic [63:0] hash, input logic [31:0] fold);
      fnvnp_pkg::result_t r;
      if (digest_q.size() == 0) begin
        report($sformatf("unexpected result hash %h fold %h", hash, fold));
      end else begin
        r = digest_q.pop_front();
        if (hash !== r.file_hash)
          report($sformatf("file_hash got %h expected %h", hash, r.file_hash));
        if (fold !== r.folded_id)
          report($sformatf("folded_id got %h expected %h", fold, r.folded_id));
      end
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  req_type_i  = fnvnp_pkg::REQ_DATASET;
  logic [7:0]  data_byte_i = 8'd0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] file_hash_o;
  logic [31:0] folded_id_o;

  fnv_pair_scoreboard sb = new();

  bit          tx_quiet     = 1'b1;
  bit          rx_quiet     = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned taken_beats  = 0;
  int unsigned idle_cycles  = 0;

  fnv1a64_name_pair_hash_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .file_hash_o (file_hash_o),
    .folded_id_o (folded_id_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] name_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(input logic [1:0] req, input logic [7:0] b);
    int unsigned gap;
    gap = idle_gap(tx_quiet);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req, b);
    taken_beats++;
  endtask

  task automatic send_name_pair();
    int unsigned kind;
    int unsigned dlen;
    int unsigned mlen;
    int unsigned n;
    logic [1:0]  req;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 50) : $urandom_range(0, 12);
      mlen = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 8);
      repeat (dlen) send_beat(fnvnp_pkg::REQ_DATASET, name_byte());
      if ($urandom_range(0, 7) != 0) send_beat(fnvnp_pkg::REQ_SEPARATOR, name_byte());
      repeat (mlen) send_beat(fnvnp_pkg::REQ_MEMBER, name_byte());
      send_beat(fnvnp_pkg::REQ_FINISH, name_byte());
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        req = 2'($urandom_range(0, 3));
        send_beat(req, name_byte());
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: random stall, plus one long hold-off on request
  initial begin : rx_stall
    int unsigned stall_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (1 + $urandom_range(0, 8)) @(posedge clk_i);
      stall_len = idle_gap(rx_quiet);
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_digest(file_hash_o, folded_id_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    bit hold_done;
    bit drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pair, finish without separator
    send_beat(fnvnp_pkg::REQ_FINISH, 8'hFF);
    // extreme bytes in both parts
    send_beat(fnvnp_pkg::REQ_DATASET, 8'h00);
    send_beat(fnvnp_pkg::REQ_DATASET, 8'hFF);
    send_beat(fnvnp_pkg::REQ_SEPARATOR, 8'hFF);
    send_beat(fnvnp_pkg::REQ_MEMBER, 8'hFF);
    send_beat(fnvnp_pkg::REQ_MEMBER, 8'h00);
    send_beat(fnvnp_pkg::REQ_FINISH, 8'h00);
    // member byte before separator, then finish without separator
    send_beat(fnvnp_pkg::REQ_MEMBER, 8'h41);
    send_beat(fnvnp_pkg::REQ_DATASET, 8'h5A);
    send_beat(fnvnp_pkg::REQ_FINISH, 8'hAA);
    // dataset byte after separator, repeated separator
    send_beat(fnvnp_pkg::REQ_DATASET, 8'h01);
    send_beat(fnvnp_pkg::REQ_SEPARATOR, 8'h55);
    send_beat(fnvnp_pkg::REQ_DATASET, 8'h80);
    send_beat(fnvnp_pkg::REQ_SEPARATOR, 8'h00);
    send_beat(fnvnp_pkg::REQ_MEMBER, 8'h7F);
    send_beat(fnvnp_pkg::REQ_FINISH, 8'h0F);
    // empty dataset name with separator
    send_beat(fnvnp_pkg::REQ_SEPARATOR, 8'hF0);
    send_beat(fnvnp_pkg::REQ_FINISH, 8'h33);

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    while (taken_beats < TOTAL_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (!hold_done && taken_beats >= 300) begin
        hold_done    = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!drain_done && taken_beats >= 600) begin
        drain_done = 1'b1;
        drain_results();
      end
      send_name_pair();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/fnvnp_pkg.sv
hdl/fnvnp_in_stage.sv
hdl/fnvnp_hash_unit.sv
hdl/fnvnp_out_stage.sv
hdl/fnv1a64_name_pair_hash_core.sv
tb/tb.sv
